/* rtl/wce_pkg.sv */
// Shared types and constants for the wheel cipher encrypter.
// Used by the letter table memory and by the top level; depends on nothing else.
`default_nettype none

package wce_pkg;

    localparam int unsigned LETTERS    = 26;
    localparam int unsigned MAX_DISKS  = 16;
    localparam int unsigned DISK_W     = 4;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned TBL_ADDR_W = DISK_W + POS_W;
    localparam int unsigned TBL_DEPTH  = 1 << TBL_ADDR_W;

    localparam logic [7:0] ASCII_A = 8'd65;
    localparam logic [7:0] ASCII_Z = 8'd90;

    typedef enum logic [1:0] {
        CFG_ROW_OFFSET = 2'd0,
        CFG_DISK_COUNT = 2'd1,
        CFG_DISK_ORDER = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_ENCRYPT = 1'b1
    } opcode_t;

    // Write port of a letter table.
    typedef struct packed {
        logic                  en;
        logic [TBL_ADDR_W-1:0] addr;
        logic [POS_W-1:0]      data;
    } tbl_wr_t;

    // Reduces a 5-bit value below 26; written entries are always below 26 already.
    function automatic logic [POS_W-1:0] mod26(input logic [POS_W-1:0] v);
        logic [POS_W-1:0] r;
        r = (v >= POS_W'(LETTERS)) ? v - POS_W'(LETTERS) : v;
        return r;
    endfunction

    // Disk number sitting at a key slot.
    function automatic logic [DISK_W-1:0] disk_at(input logic [63:0] order,
                                                  input logic [DISK_W-1:0] slot);
        logic [5:0] base;
        base = {slot, 2'b00};
        return order[base +: DISK_W];
    endfunction

endpackage

`default_nettype wire

/* rtl/wce_table.sv */
// One letter table: 16 disks of 32 entries, 5 bits each, registered read.
// Depends on wce_pkg for the write port type and the address width.
`default_nettype none

module wce_table (
    input  wire logic                           clk,
    input  wire wce_pkg::tbl_wr_t               wr,
    input  wire logic                           rd_en,
    input  wire logic [wce_pkg::TBL_ADDR_W-1:0] rd_addr,
    output logic      [wce_pkg::POS_W-1:0]      rd_data
);
    import wce_pkg::*;

    logic [POS_W-1:0] mem [TBL_DEPTH];

    // Read returns the old contents when the same edge writes the same entry.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

endmodule

`default_nettype wire

/* rtl/wheel_cipher_encrypt_top.sv */
// Wheel cipher encrypter: takes one load or message byte per cycle while item_stall is low.
// Depends on wce_pkg and wce_table (forward and inverse letter tables).
// Pipeline: inverse table read, forward table read, output register.
// A short message is padded one letter per cycle, held by result_stall; input stalls meanwhile.
// Reset initialises control and configuration only; table contents are undefined until loaded.
`default_nettype none

module wheel_cipher_encrypt_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic       opcode,
    input  wire logic [3:0] disk_sel,
    input  wire logic [4:0] wheel_pos,
    input  wire logic [7:0] char_in,
    input  wire logic       last_char,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [6:0]      cipher_char,
    output logic [3:0]      slot,
    output logic            error,
    output logic            last_out
);
    import wce_pkg::*;

    typedef struct packed {
        logic              valid;
        logic              pad;
        logic              err;
        logic              last;
        logic [DISK_W-1:0] slot;
        logic [DISK_W-1:0] disk;
    } stage_t;

    logic [POS_W-1:0]  row_offset_reg;
    logic [POS_W-1:0]  disk_count_reg;
    logic [63:0]       disk_order_reg;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              pad_active_reg, pad_active_next;
    logic [DISK_W-1:0] pad_slot_reg, pad_slot_next;
    stage_t            s1_reg, s1_next;
    stage_t            s2_reg;
    logic              res_valid_reg;
    logic [6:0]        cipher_reg;
    logic [3:0]        slot_reg;
    logic              error_reg;
    logic              last_reg;

    logic              adv;
    logic              accept;
    logic              is_letter;
    logic [POS_W-1:0]  letter_idx;
    logic [POS_W-1:0]  off_eff;
    logic [POS_W-1:0]  count_eff;
    logic              in_range;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  pad_inc;
    logic [POS_W-1:0]  lp_data;
    logic [POS_W-1:0]  wl_data;
    logic [POS_W-1:0]  place;
    logic [POS_W:0]    place_sum;
    logic [POS_W-1:0]  rot_place;
    tbl_wr_t           lp_wr;
    tbl_wr_t           wl_wr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_offset_reg <= POS_W'(1);
            disk_count_reg <= POS_W'(12);
            disk_order_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ROW_OFFSET: row_offset_reg <= cfg_data[POS_W-1:0];
                CFG_DISK_COUNT: disk_count_reg <= cfg_data[POS_W-1:0];
                CFG_DISK_ORDER: disk_order_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign off_eff   = (row_offset_reg == '0) ? POS_W'(1) :
                       (row_offset_reg > POS_W'(LETTERS - 1)) ? POS_W'(LETTERS - 1) :
                       row_offset_reg;
    assign count_eff = (disk_count_reg == '0) ? POS_W'(1) :
                       (disk_count_reg > POS_W'(MAX_DISKS)) ? POS_W'(MAX_DISKS) :
                       disk_count_reg;

    // The whole pipeline moves whenever the output register can take a new result.
    assign adv        = !res_valid_reg || !result_stall;
    assign item_stall = !adv || pad_active_reg;
    assign accept     = item_valid && !item_stall;

    assign is_letter  = (char_in >= ASCII_A) && (char_in <= ASCII_Z);
    assign letter_idx = POS_W'(char_in - ASCII_A);
    assign in_range   = pos_reg < count_eff;
    assign pos_inc    = pos_reg + POS_W'(1);
    assign pad_inc    = {1'b0, pad_slot_reg} + POS_W'(1);

    always_comb
    begin
        lp_wr.en   = accept && (opcode_t'(opcode) == OP_LOAD) && is_letter &&
                     (wheel_pos < POS_W'(LETTERS));
        lp_wr.addr = {disk_sel, letter_idx};
        lp_wr.data = wheel_pos;
        wl_wr.en   = lp_wr.en;
        wl_wr.addr = {disk_sel, wheel_pos};
        wl_wr.data = letter_idx;
    end

    // Message position, padding sequencer and first pipeline stage.
    always_comb
    begin
        pos_next        = pos_reg;
        pad_active_next = pad_active_reg;
        pad_slot_next   = pad_slot_reg;
        s1_next         = s1_reg;
        if (adv)
        begin
            s1_next.valid = 1'b0;
            if (accept && (opcode_t'(opcode) == OP_ENCRYPT))
            begin
                s1_next.valid = in_range;
                s1_next.pad   = 1'b0;
                s1_next.err   = !is_letter;
                s1_next.last  = last_char && (pos_inc >= count_eff);
                s1_next.slot  = pos_reg[DISK_W-1:0];
                s1_next.disk  = disk_at(disk_order_reg, pos_reg[DISK_W-1:0]);
                if (last_char)
                begin
                    pos_next = '0;
                    if (in_range && (pos_inc < count_eff))
                    begin
                        pad_active_next = 1'b1;
                        pad_slot_next   = pos_inc[DISK_W-1:0];
                    end
                end
                else if (in_range)
                begin
                    pos_next = pos_inc;
                end
            end
            else if (pad_active_reg)
            begin
                s1_next.valid = 1'b1;
                s1_next.pad   = 1'b1;
                s1_next.err   = 1'b0;
                s1_next.last  = (pad_inc == count_eff);
                s1_next.slot  = pad_slot_reg;
                s1_next.disk  = disk_at(disk_order_reg, pad_slot_reg);
                pad_slot_next = pad_inc[DISK_W-1:0];
                if (pad_inc == count_eff)
                begin
                    pad_active_next = 1'b0;
                end
            end
        end
    end

    // Padding letters are read as though the message letter sat at place zero.
    assign place     = s1_reg.pad ? '0 : mod26(lp_data);
    assign place_sum = {1'b0, place} + {1'b0, off_eff};
    assign rot_place = (place_sum >= (POS_W + 1)'(LETTERS)) ?
                       POS_W'(place_sum - (POS_W + 1)'(LETTERS)) : place_sum[POS_W-1:0];

    wce_table u_letter_places (
        .clk     (clk),
        .wr      (lp_wr),
        .rd_en   (adv),
        .rd_addr ({disk_at(disk_order_reg, pos_reg[DISK_W-1:0]), letter_idx}),
        .rd_data (lp_data)
    );

    wce_table u_wheel_letters (
        .clk     (clk),
        .wr      (wl_wr),
        .rd_en   (adv),
        .rd_addr ({s1_reg.disk, rot_place}),
        .rd_data (wl_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            pad_active_reg <= 1'b0;
            pad_slot_reg   <= '0;
            s1_reg         <= '0;
            s2_reg         <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            pad_active_reg <= pad_active_next;
            pad_slot_reg   <= pad_slot_next;
            s1_reg         <= s1_next;
            if (adv)
            begin
                s2_reg        <= s1_reg;
                res_valid_reg <= s2_reg.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cipher_reg <= s2_reg.err ? 7'd0 :
                          7'(ASCII_A) + {2'b00, mod26(wl_data)};
            slot_reg   <= s2_reg.slot;
            error_reg  <= s2_reg.err;
            last_reg   <= s2_reg.last;
        end
    end

    assign result_valid = res_valid_reg;
    assign cipher_char  = cipher_reg;
    assign slot         = slot_reg;
    assign error        = error_reg;
    assign last_out     = last_reg;

endmodule

`default_nettype wire

/* test/wheel_cipher_encrypt_top_test.sv */
// Self-checking testbench for wheel_cipher_encrypt_top: loads four disks, walks a directed
// table, then runs random messages under several register settings and idling patterns.
// Depends on wce_pkg and the RTL of the block; needs no files or arguments.

module wheel_cipher_encrypt_top_test;

    import wce_pkg::*;

    typedef struct {
        opcode_t    op;
        logic [3:0] dsel;
        logic [4:0] wpos;
        logic [7:0] ch;
        logic       last;
    } stim_t;

    typedef struct {
        logic [6:0] cipher_char;
        logic [3:0] slot;
        logic       error;
        logic       last_out;
    } letter_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // How a directed row is checked: by the predictor, against a typed-in result, or not at all.
    localparam int CHECK_MODEL = -1;
    localparam int CHECK_NONE  = 0;
    localparam int CHECK_ONE   = 1;

    // Only disks 0, 5, 10 and 15 are filled in full, and every key names only those.
    localparam int LOADED_DISKS = 4;
    localparam int DISK_STEP    = 5;

    localparam letter_t NO_LETTER = '{7'd0, 4'd0, 1'b0, 1'b0};

    typedef struct {
        row_kind_t   kind;
        cfg_idx_t    idx;
        logic [63:0] value;
        stim_t       s;
        int          check;
        letter_t     want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_idx_t    cfg_index = CFG_ROW_OFFSET;
    logic [63:0] cfg_data = '0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        opcode = OP_LOAD;
    logic [3:0]  disk_sel = '0;
    logic [4:0]  wheel_pos = '0;
    logic [7:0]  char_in = '0;
    logic        last_char = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [6:0]  cipher_char;
    logic [3:0]  slot;
    logic        error;
    logic        last_out;

    // Shadow of the block: letter tables, message position and registers.
    logic [4:0]  wheel_tab [MAX_DISKS][LETTERS];
    logic [4:0]  place_tab [MAX_DISKS][LETTERS];
    int          msg_pos = 0;
    logic [4:0]  row_offset_r = 5'd1;
    logic [4:0]  disk_count_r = 5'd12;
    logic [63:0] disk_order_r = '0;

    letter_t     step_out [MAX_DISKS];
    int          step_n;
    letter_t     letters_due [$];
    dir_row_t    dir_rows [$];

    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int encrypts_sent = 0;
    int letters_seen = 0;
    int bad_bytes_seen = 0;
    int settings_used = 0;
    int mismatches = 0;

    wheel_cipher_encrypt_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .opcode       (opcode),
        .disk_sel     (disk_sel),
        .wheel_pos    (wheel_pos),
        .char_in      (char_in),
        .last_char    (last_char),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cipher_char  (cipher_char),
        .slot         (slot),
        .error        (error),
        .last_out     (last_out)
    );

    always #4 clk = ~clk;

    function automatic int disks_in_use();
        if (disk_count_r < 1)
            return 1;
        if (disk_count_r > MAX_DISKS)
            return MAX_DISKS;
        return disk_count_r;
    endfunction

    // A random key whose slots all name filled disks.
    function automatic logic [63:0] random_order();
        logic [63:0] o;
        for (int k = 0; k < MAX_DISKS; k++)
            o[4 * k +: 4] = 4'(DISK_STEP * $urandom_range(0, LOADED_DISKS - 1));
        return o;
    endfunction

    function automatic void queue_letter(input letter_t l);
        letters_due = {letters_due, l};
    endfunction

    function automatic logic [6:0] letter_on(input int d, input int place, input int off);
        return 7'(ASCII_A + wheel_tab[d][(place + off) % LETTERS]);
    endfunction

    // Works out the letters that one accepted transaction causes, into step_out; loads update the tables.
    function automatic void predict_cipher(input stim_t s);
        int off;
        int cnt;
        int li;
        int d;
        bit is_letter;
        off = (row_offset_r < 1) ? 1 : (row_offset_r > 25) ? 25 : row_offset_r;
        cnt = disks_in_use();
        is_letter = (s.ch >= ASCII_A) && (s.ch <= ASCII_Z);
        step_n = 0;
        if (s.op == OP_LOAD)
        begin
            if (s.wpos < LETTERS && is_letter)
            begin
                li = s.ch - ASCII_A;
                wheel_tab[s.dsel][s.wpos] = 5'(li);
                place_tab[s.dsel][li] = s.wpos;
            end
            return;
        end
        if (msg_pos < cnt)
        begin
            step_out[0].slot = 4'(msg_pos);
            step_out[0].last_out = 1'b0;
            step_out[0].error = !is_letter;
            if (is_letter)
            begin
                d = disk_order_r[4 * msg_pos +: 4];
                step_out[0].cipher_char = letter_on(d, place_tab[d][s.ch - ASCII_A], off);
            end
            else
                step_out[0].cipher_char = 7'd0;
            step_n = 1;
            msg_pos++;
        end
        if (s.last)
        begin
            // Unused disks are padded as though the message letter sat at place zero.
            while (msg_pos < cnt)
            begin
                d = disk_order_r[4 * msg_pos +: 4];
                step_out[step_n] = '{letter_on(d, 0, off), 4'(msg_pos), 1'b0, 1'b0};
                step_n++;
                msg_pos++;
            end
            if (step_n > 0)
                step_out[step_n - 1].last_out = 1'b1;
            msg_pos = 0;
        end
    endfunction

    task automatic send_item(input stim_t s);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        opcode     <= s.op;
        disk_sel   <= s.dsel;
        wheel_pos  <= s.wpos;
        char_in    <= s.ch;
        last_char  <= s.last;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        if (s.op == OP_ENCRYPT)
            encrypts_sent++;
    endtask

    task automatic encrypt_and_expect(input stim_t s);
        send_item(s);
        predict_cipher(s);
        for (int k = 0; k < step_n; k++)
            queue_letter(step_out[k]);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (letters_due.size() != 0)
            @(posedge clk);
    endtask

    // A transaction with no result may still be in the pipeline, hence the extra cycles.
    task automatic write_register(input cfg_idx_t idx, input logic [63:0] value);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ROW_OFFSET: row_offset_r = value[4:0];
            CFG_DISK_COUNT: disk_count_r = value[4:0];
            CFG_DISK_ORDER: disk_order_r = value;
            default: ;
        endcase
        settings_used++;
    endtask

    function automatic dir_row_t item_row(input opcode_t op, input logic [3:0] d,
                                          input logic [4:0] w, input logic [7:0] c,
                                          input logic l, input int check,
                                          input letter_t want);
        dir_row_t r;
        r.kind = ROW_ITEM;
        r.idx = CFG_ROW_OFFSET;
        r.value = '0;
        r.s = '{op, d, w, c, l};
        r.check = check;
        r.want = want;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input cfg_idx_t idx, input logic [63:0] value);
        dir_row_t r;
        r = item_row(OP_LOAD, 4'd0, 5'd0, 8'd0, 1'b0, CHECK_NONE, NO_LETTER);
        r.kind = ROW_CFG;
        r.idx = idx;
        r.value = value;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        letter_t got;
        letter_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = '{cipher_char, slot, error, last_out};
            letters_seen++;
            if (error)
                bad_bytes_seen++;
            if (letters_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: result with none expected: char=%0d slot=%0d err=%0d last=%0d",
                             $time, got.cipher_char, got.slot, got.error, got.last_out);
            end
            else
            begin
                want = letters_due.pop_front();
                if (got.cipher_char !== want.cipher_char || got.slot !== want.slot ||
                    got.error !== want.error || got.last_out !== want.last_out)
                begin
                    mismatches++;
                    if (mismatches <= 40)
                    begin
                        $display("%0t: mismatch, expected char=%0d slot=%0d err=%0d last=%0d",
                                 $time, want.cipher_char, want.slot, want.error,
                                 want.last_out);
                        $display("%0t:           got      char=%0d slot=%0d err=%0d last=%0d",
                                 $time, got.cipher_char, got.slot, got.error, got.last_out);
                    end
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int perm [LETTERS];
        int j;
        int tmp;
        int len;
        int enc_start;
        logic [63:0] off;
        logic [63:0] cnt;
        logic [63:0] order;
        stim_t s;
        dir_row_t r;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Fill each keyed disk with a shuffled alphabet so that no table entry is read unwritten.
        for (int k = 0; k < LOADED_DISKS; k++)
        begin
            for (int p = 0; p < LETTERS; p++)
                perm[p] = p;
            for (int p = LETTERS - 1; p > 0; p--)
            begin
                j = $urandom_range(0, p);
                tmp = perm[p];
                perm[p] = perm[j];
                perm[j] = tmp;
            end
            for (int p = 0; p < LETTERS; p++)
                encrypt_and_expect('{OP_LOAD, 4'(DISK_STEP * k), 5'(p),
                                     8'(ASCII_A + perm[p]), 1'($urandom_range(0, 1))});
        end

        dir_rows = '{
            cfg_row(CFG_ROW_OFFSET, 64'd0),
            item_row(OP_LOAD, 4'd0, 5'd26, "A", 1'b0, CHECK_NONE, NO_LETTER),
            item_row(OP_LOAD, 4'd15, 5'd31, "Z", 1'b1, CHECK_NONE, NO_LETTER),
            item_row(OP_LOAD, 4'd0, 5'd0, 8'h40, 1'b0, CHECK_NONE, NO_LETTER),
            item_row(OP_LOAD, 4'd15, 5'd25, 8'h5B, 1'b0, CHECK_NONE, NO_LETTER),
            item_row(OP_LOAD, 4'd0, 5'd0, "Z", 1'b0, CHECK_MODEL, NO_LETTER),
            item_row(OP_LOAD, 4'd15, 5'd25, "A", 1'b0, CHECK_MODEL, NO_LETTER),
            item_row(OP_ENCRYPT, 4'd15, 5'd31, 8'h40, 1'b0, CHECK_ONE,
                     '{7'd0, 4'd0, 1'b1, 1'b0}),
            item_row(OP_ENCRYPT, 4'd0, 5'd0, "A", 1'b0, CHECK_MODEL, NO_LETTER),
            item_row(OP_ENCRYPT, 4'd0, 5'd0, "Z", 1'b0, CHECK_MODEL, NO_LETTER),
            item_row(OP_ENCRYPT, 4'd5, 5'd17, 8'hFF, 1'b0, CHECK_ONE,
                     '{7'd0, 4'd3, 1'b1, 1'b0}),
            item_row(OP_ENCRYPT, 4'd10, 5'd14, 8'h00, 1'b1, CHECK_MODEL, NO_LETTER),
            cfg_row(CFG_DISK_COUNT, 64'd31),
            cfg_row(CFG_DISK_ORDER, 64'hF0A5_5AF0_0FA5_A50F),
            item_row(OP_ENCRYPT, 4'd0, 5'd0, "M", 1'b1, CHECK_MODEL, NO_LETTER),
            cfg_row(CFG_ROW_OFFSET, 64'd31),
            cfg_row(CFG_DISK_COUNT, 64'd0),
            item_row(OP_ENCRYPT, 4'd0, 5'd0, 8'h5B, 1'b0, CHECK_ONE,
                     '{7'd0, 4'd0, 1'b1, 1'b0}),
            item_row(OP_ENCRYPT, 4'd0, 5'd0, "B", 1'b0, CHECK_NONE, NO_LETTER),
            item_row(OP_ENCRYPT, 4'd0, 5'd0, "C", 1'b1, CHECK_NONE, NO_LETTER),
            item_row(OP_ENCRYPT, 4'd0, 5'd0, "Q", 1'b1, CHECK_MODEL, NO_LETTER),
            cfg_row(CFG_DISK_COUNT, 64'd16),
            item_row(OP_ENCRYPT, 4'd0, 5'd0, "K", 1'b1, CHECK_MODEL, NO_LETTER)
        };

        idle_pct = 28;
        stall_pct = 28;
        foreach (dir_rows[n])
        begin
            r = dir_rows[n];
            if (r.kind == ROW_CFG)
                write_register(r.idx, r.value);
            else if (r.check == CHECK_MODEL)
                encrypt_and_expect(r.s);
            else
            begin
                // The shadow state still advances; the typed-in result, if any, replaces its output.
                send_item(r.s);
                predict_cipher(r.s);
                if (r.check == CHECK_ONE)
                    queue_letter(r.want);
            end
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            order = random_order();
            off = $urandom_range(1, 25);
            cnt = $urandom_range(1, 16);
            case (ph)
                0:
                begin
                    off = 1;
                    cnt = 16;
                    order = '1;
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    off = 25;
                    cnt = 1;
                    idle_pct = 45;
                    stall_pct = 0;
                end
                2:
                begin
                    off = $urandom_range(2, 24);
                    cnt = $urandom_range(2, 15);
                    idle_pct = 0;
                    stall_pct = 45;
                end
                3:
                begin
                    cnt = 4;
                    order = '0;
                    idle_pct = 28;
                    stall_pct = 28;
                end
                4:
                begin
                    idle_pct = 28;
                    stall_pct = 28;
                end
                default:
                begin
                    off = 13;
                    cnt = 12;
                    idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            write_register(CFG_ROW_OFFSET, off);
            write_register(CFG_DISK_COUNT, cnt);
            write_register(CFG_DISK_ORDER, order);

            enc_start = encrypts_sent;
            while (encrypts_sent - enc_start < 20)
            begin
                len = $urandom_range(1, disks_in_use() + 2);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 11) == 0)
                    begin
                        s.op = OP_LOAD;
                        s.dsel = 4'($urandom);
                        s.wpos = 5'($urandom);
                        s.ch = $urandom_range(0, 1) ? 8'(ASCII_A + $urandom_range(0, 25))
                                                    : 8'($urandom);
                        s.last = 1'($urandom);
                        encrypt_and_expect(s);
                    end
                    s.op = OP_ENCRYPT;
                    s.dsel = 4'($urandom);
                    s.wpos = 5'($urandom);
                    s.ch = ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                       : 8'(ASCII_A + $urandom_range(0, 25));
                    s.last = (i == len - 1);
                    encrypt_and_expect(s);
                end
                if ($urandom_range(0, 14) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (letters_due.size() != 0)
        begin
            $display("%0t: %0d expected result transactions never arrived",
                     $time, letters_due.size());
            mismatches += letters_due.size();
        end

        $display("Covered %0d input transactions (%0d encrypt) and %0d result transactions,",
                 items_sent, encrypts_sent, letters_seen);
        $display("%0d of them bad-byte flags, across %0d register writes.",
                 bad_bytes_seen, settings_used);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
rtl/wce_pkg.sv
rtl/wce_table.sv
rtl/wheel_cipher_encrypt_top.sv
test/wheel_cipher_encrypt_top_test.sv
